// ----- rtl/rnpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rnpc_pkg
// Shared constants and types of the rigid-align nearest-point cost core.
// ----------------------------------------------------------------------------
package rnpc_pkg;

   localparam int MAX_PAIRS_DEF = 256;   // default store depth
   localparam int CRD_W         = 24;    // point coordinate, 8 fraction bits
   localparam int ROT_W         = 16;    // Q2.14 matrix entry
   localparam int COST_W        = 24;    // result width
   localparam int DIST_W        = 28;    // bits of the distance limit
   localparam int DIST_LIMIT    = 256000000;
   localparam int CSR_IDX_W     = 3;
   localparam int SQ_IN_W       = 64;    // squared distance width

   // configuration register index codes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_00  = 3'd0,
      CSR_ROT_01  = 3'd1,
      CSR_ROT_10  = 3'd2,
      CSR_ROT_11  = 3'd3,
      CSR_SHIFT_X = 3'd4,
      CSR_SHIFT_Y = 3'd5,
      CSR_MATCH   = 3'd6
   } csr_index_type;

   // sequencer states, one-hot
   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_CXGO  = 15'b000000000000010,
      ST_CXW   = 15'b000000000000100,
      ST_CYGO  = 15'b000000000001000,
      ST_CYW   = 15'b000000000010000,
      ST_PRD   = 15'b000000000100000,
      ST_PDIF  = 15'b000000001000000,
      ST_PMUL  = 15'b000000010000000,
      ST_PSUM  = 15'b000000100000000,
      ST_SCAN  = 15'b000001000000000,
      ST_SQGO  = 15'b000010000000000,
      ST_SQW   = 15'b000100000000000,
      ST_MGO   = 15'b001000000000000,
      ST_MW    = 15'b010000000000000,
      ST_DONE  = 15'b100000000000000
   } state_type;

endpackage : rnpc_pkg
`default_nettype wire

// ----- rtl/rnpc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rnpc_div
// Serial restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rnpc_div
   import rnpc_pkg::*;
#(
   parameter int NW = 36,
   parameter int DW = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   output logic               done,
   output logic [NW-1:0]      quot
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    num_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DW:0]      rem_sh;
   logic             ge;
   logic [DW:0]      rem_nx;

   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_nx = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         den_ff <= denom;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NW-2:0], ge};
         rem_ff <= rem_nx[DW-1:0];
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule : rnpc_div
`default_nettype wire

// ----- rtl/rnpc_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rnpc_sqrt
// Serial integer square root (floor), one root bit per cycle.
// ----------------------------------------------------------------------------
module rnpc_sqrt
   import rnpc_pkg::*;
#(
   parameter int IW = SQ_IN_W
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [IW-1:0]   radicand,
   output logic                 done,
   output logic [IW/2-1:0]      root
);

   localparam int RW    = IW / 2;
   localparam int CNT_W = $clog2(RW + 1);

   logic [IW-1:0]    val_ff;
   logic [RW:0]      rem_ff;
   logic [RW-1:0]    root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [RW+2:0]    rem_sh;
   logic [RW+2:0]    trial;
   logic             ge;
   logic [RW+2:0]    rem_nx;

   assign rem_sh = {rem_ff, val_ff[IW-1:IW-2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;
   assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(RW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[IW-3:0], 2'b00};
         rem_ff  <= rem_nx[RW:0];
         root_ff <= {root_ff[RW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule : rnpc_sqrt
`default_nettype wire

// ----- rtl/rigid_align_nearest_point_cost_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_align_nearest_point_cost_core
// Mean nearest-point distance of a rigidly transformed point set.
// ----------------------------------------------------------------------------
// Each input item carries one point pair (previous point, mapped current
// point, signed 24 bit with 8 fraction bits) and is written into two
// synchronous memories of MAX_PAIRS entries while the previous points are
// summed; pairs past MAX_PAIRS are dropped. A non-final item is taken
// whenever the core is idle. The item flagged by tlast starts the cost
// pass: the centroid (two serial divisions), then for each of the n stored
// pairs a transform, a pipelined scan of all n current points (one memory
// read per cycle), and a serial square root, and finally the mean division.
// While the pass runs, no item is taken. If match_present is 0 the result
// is no_match=1, cost 0, with no pass. The result waits in an output
// register; the next set can load while it is pending. Configuration must
// be written only while idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module rigid_align_nearest_point_cost_core
   import rnpc_pkg::*;
#(
   parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input items
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [4*CRD_W-1:0]   req_tdata,  // prev_x, prev_y, cur_x, cur_y
   input  wire logic                 req_tlast,  // last_pair
   // result items
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [COST_W-1:0]         rsp_tdata,  // mean_cost
   output logic                      rsp_tuser,  // no_match
   // configuration writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CRD_W-1:0]     csr_data
);

   localparam int CW   = $clog2(MAX_PAIRS + 1);          // pair count
   localparam int AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int SW   = CRD_W + CW;                      // coordinate sum
   localparam int TW   = DIST_W + CW;                     // distance total
   localparam int DNW  = TW;                              // divider numerator
   localparam int DDW  = CW + 1;                          // divider denominator
   localparam int CXW  = CRD_W + 1;                       // centroid
   localparam int DXW  = CRD_W + 2;                       // offset from centroid
   localparam int PW   = ROT_W + DXW;                     // rotation product
   localparam int TXW  = PW + 1 - 14 + 2;                 // transformed point
   localparam int EXW  = TXW + 1;                         // point difference
   localparam int RTW  = SQ_IN_W / 2;                     // square root

   localparam logic [CW-1:0]     MAX_CNT    = CW'(MAX_PAIRS);
   localparam logic signed [PW:0] ROUND_HALF = (PW+1)'(8192);
   localparam logic [RTW-1:0]    LIMIT      = RTW'(DIST_LIMIT);
   localparam logic [SQ_IN_W-1:0] BEST_INIT = '1;

   // ---------------- configuration registers ----------------
   logic signed [ROT_W-1:0] rot_00_ff, rot_01_ff, rot_10_ff, rot_11_ff;
   logic signed [CRD_W-1:0] shift_x_ff, shift_y_ff;
   logic                    match_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_00_ff  <= ROT_W'(16384);
         rot_01_ff  <= '0;
         rot_10_ff  <= '0;
         rot_11_ff  <= ROT_W'(16384);
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         match_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROT_00:  rot_00_ff  <= csr_data[ROT_W-1:0];
            CSR_ROT_01:  rot_01_ff  <= csr_data[ROT_W-1:0];
            CSR_ROT_10:  rot_10_ff  <= csr_data[ROT_W-1:0];
            CSR_ROT_11:  rot_11_ff  <= csr_data[ROT_W-1:0];
            CSR_SHIFT_X: shift_x_ff <= csr_data;
            CSR_SHIFT_Y: shift_y_ff <= csr_data;
            CSR_MATCH:   match_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- input fields ----------------
   logic signed [CRD_W-1:0] in_px, in_py, in_qx, in_qy;
   logic                    in_acc;
   logic                    in_store;
   logic [CW-1:0]           cnt_ff;

   assign in_px    = req_tdata[CRD_W-1:0];
   assign in_py    = req_tdata[2*CRD_W-1:CRD_W];
   assign in_qx    = req_tdata[3*CRD_W-1:2*CRD_W];
   assign in_qy    = req_tdata[4*CRD_W-1:3*CRD_W];
   assign in_acc   = req_tvalid && req_tready;
   assign in_store = in_acc && (cnt_ff < MAX_CNT);

   // ---------------- state ----------------
   state_type state_ff, state_in;

   logic signed [SW-1:0]    sum_x_ff, sum_y_ff;
   logic [CW-1:0]           i_ff, j_ff;
   logic                    neg_ff;
   logic signed [CXW-1:0]   cx_ff, cy_ff;
   logic signed [DXW-1:0]   dx_ff, dy_ff;
   logic signed [PW-1:0]    m00_ff, m01_ff, m10_ff, m11_ff;
   logic signed [TXW-1:0]   tx_ff, ty_ff;
   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [EXW-1:0]   ex_ff, ey_ff;
   logic [SQ_IN_W-1:0]      sqx_ff, sqy_ff;
   logic [SQ_IN_W-1:0]      best_ff;
   logic [TW-1:0]           total_ff;
   logic [COST_W-1:0]       cost_ff;
   logic                    nomatch_ff;
   logic                    rsp_valid_ff;
   logic [COST_W-1:0]       rsp_data_ff;
   logic                    rsp_user_ff;

   // point memories: {y, x}
   logic [2*CRD_W-1:0] prev_mem [MAX_PAIRS];
   logic [2*CRD_W-1:0] cur_mem  [MAX_PAIRS];
   logic [2*CRD_W-1:0] prev_rd_ff, cur_rd_ff;

   always_ff @(posedge clock) begin
      if (in_store) begin
         prev_mem[cnt_ff[AW-1:0]] <= {in_py, in_px};
         cur_mem[cnt_ff[AW-1:0]]  <= {in_qy, in_qx};
      end
      prev_rd_ff <= prev_mem[i_ff[AW-1:0]];
      cur_rd_ff  <= cur_mem[j_ff[AW-1:0]];
   end

   // ---------------- shared divider ----------------
   logic                   div_start;
   logic [DNW-1:0]         div_numer;
   logic [DDW-1:0]         div_denom;
   logic                   div_done;
   logic [DNW-1:0]         div_quot;
   logic signed [SW+1:0]   cnum;
   logic signed [SW+1:0]   cmag;
   logic signed [SW-1:0]   sel_sum;
   logic [DDW-1:0]         two_n;

   assign sel_sum   = (state_ff == ST_CYGO) ? sum_y_ff : sum_x_ff;
   assign two_n     = {cnt_ff, 1'b0};
   // floor((2*sum + n) / (2n)); a negative numerator divides |a| + 2n - 1
   assign cnum      = ((SW+2)'(sel_sum) <<< 1) + $signed((SW+2)'(cnt_ff));
   assign cmag      = cnum[SW+1] ? (-cnum + $signed((SW+2)'(two_n - 1'b1))) : cnum;
   assign div_start = (state_ff == ST_CXGO) || (state_ff == ST_CYGO)
                    || (state_ff == ST_MGO);
   assign div_numer = (state_ff == ST_MGO) ? total_ff : DNW'($unsigned(cmag));
   assign div_denom = (state_ff == ST_MGO) ? {1'b0, cnt_ff} : two_n;

   rnpc_div #(
      .NW (DNW),
      .DW (DDW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   logic signed [CXW-1:0] quot_s;
   logic signed [CXW-1:0] cen_in;

   assign quot_s = $signed(div_quot[CXW-1:0]);
   assign cen_in = neg_ff ? -quot_s : quot_s;

   // ---------------- square root ----------------
   logic             sq_start;
   logic             sq_done;
   logic [RTW-1:0]   sq_root;

   assign sq_start = (state_ff == ST_SQGO);

   rnpc_sqrt #(
      .IW (SQ_IN_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (best_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   // ---------------- transform datapath ----------------
   logic signed [CRD_W-1:0] rd_px, rd_py, rd_qx, rd_qy;
   logic signed [PW:0]      tsum_x, tsum_y;
   logic signed [PW:0]      tsh_x, tsh_y;
   logic [SQ_IN_W-1:0]      d2;
   logic                    issue;
   logic                    scan_end;

   assign rd_px  = prev_rd_ff[CRD_W-1:0];
   assign rd_py  = prev_rd_ff[2*CRD_W-1:CRD_W];
   assign rd_qx  = cur_rd_ff[CRD_W-1:0];
   assign rd_qy  = cur_rd_ff[2*CRD_W-1:CRD_W];
   // round half up, then floor shift by 14 fraction bits
   assign tsum_x = (PW+1)'(m00_ff) + (PW+1)'(m01_ff) + ROUND_HALF;
   assign tsum_y = (PW+1)'(m10_ff) + (PW+1)'(m11_ff) + ROUND_HALF;
   assign tsh_x  = tsum_x >>> 14;
   assign tsh_y  = tsum_y >>> 14;
   assign d2     = sqx_ff + sqy_ff;
   assign issue  = (state_ff == ST_SCAN) && (j_ff != cnt_ff);
   assign scan_end = (state_ff == ST_SCAN) && (j_ff == cnt_ff)
                   && !v1_ff && !v2_ff && !v3_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_acc && req_tlast) begin
               state_in = match_ff ? ST_CXGO : ST_DONE;
            end
         end
         ST_CXGO: state_in = ST_CXW;
         ST_CXW:  if (div_done) state_in = ST_CYGO;
         ST_CYGO: state_in = ST_CYW;
         ST_CYW:  if (div_done) state_in = ST_PRD;
         ST_PRD:  state_in = ST_PDIF;
         ST_PDIF: state_in = ST_PMUL;
         ST_PMUL: state_in = ST_PSUM;
         ST_PSUM: state_in = ST_SCAN;
         ST_SCAN: if (scan_end) state_in = ST_SQGO;
         ST_SQGO: state_in = ST_SQW;
         ST_SQW: begin
            if (sq_done) begin
               state_in = (i_ff + 1'b1 == cnt_ff) ? ST_MGO : ST_PRD;
            end
         end
         ST_MGO:  state_in = ST_MW;
         ST_MW:   if (div_done) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         if (in_store) begin
            cnt_ff   <= cnt_ff + 1'b1;
            sum_x_ff <= sum_x_ff + SW'(in_px);
            sum_y_ff <= sum_y_ff + SW'(in_py);
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == ST_DONE) && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            cnt_ff       <= '0;
            sum_x_ff     <= '0;
            sum_y_ff     <= '0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            nomatch_ff <= 1'b1;
            cost_ff    <= '0;
            total_ff   <= '0;
            i_ff       <= '0;
         end
         ST_CXGO, ST_CYGO: neg_ff <= cnum[SW+1];
         ST_CXW:  if (div_done) cx_ff <= cen_in;
         ST_CYW:  if (div_done) cy_ff <= cen_in;
         ST_PDIF: begin
            dx_ff <= DXW'(rd_px) - DXW'(cx_ff);
            dy_ff <= DXW'(rd_py) - DXW'(cy_ff);
         end
         ST_PMUL: begin
            m00_ff <= PW'(rot_00_ff) * PW'(dx_ff);
            m01_ff <= PW'(rot_01_ff) * PW'(dy_ff);
            m10_ff <= PW'(rot_10_ff) * PW'(dx_ff);
            m11_ff <= PW'(rot_11_ff) * PW'(dy_ff);
         end
         ST_PSUM: begin
            tx_ff   <= TXW'(tsh_x) + TXW'(shift_x_ff) + TXW'(cx_ff);
            ty_ff   <= TXW'(tsh_y) + TXW'(shift_y_ff) + TXW'(cy_ff);
            j_ff    <= '0;
            best_ff <= BEST_INIT;
         end
         ST_SQW: begin
            if (sq_done) begin
               if (sq_root < LIMIT) begin
                  total_ff <= total_ff + TW'(sq_root);
               end
               i_ff <= i_ff + 1'b1;
            end
         end
         ST_MW: begin
            if (div_done) begin
               nomatch_ff <= 1'b0;
               cost_ff    <= (|div_quot[DNW-1:COST_W]) ? '1 : div_quot[COST_W-1:0];
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_data_ff <= cost_ff;
               rsp_user_ff <= nomatch_ff;
            end
         end
         default: ;
      endcase
      // nearest-point scan pipeline: read, difference, squares, minimum
      if (issue) begin
         j_ff <= j_ff + 1'b1;
      end
      if (v1_ff) begin
         ex_ff <= EXW'(tx_ff) - EXW'(rd_qx);
         ey_ff <= EXW'(ty_ff) - EXW'(rd_qy);
      end
      if (v2_ff) begin
         sqx_ff <= $unsigned(SQ_IN_W'(ex_ff) * SQ_IN_W'(ex_ff));
         sqy_ff <= $unsigned(SQ_IN_W'(ey_ff) * SQ_IN_W'(ey_ff));
      end
      if (v3_ff && (d2 < best_ff)) begin
         best_ff <= d2;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("pair count above store depth");

   a_scan_in_state: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (state_ff == ST_SCAN))
      else $error("scan pipeline active outside scan");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_CXW) || (state_ff == ST_CYW) || (state_ff == ST_MW)))
      else $error("divider finished outside a wait state");
`endif

endmodule : rigid_align_nearest_point_cost_core
`default_nettype wire

// ----- dv/rigid_align_nearest_point_cost_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rigid_align_nearest_point_cost_checker
// Watches the pair, result and register channels of the cost core, keeps its
// own copy of the point sets and registers, predicts each mean cost item and
// compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module rigid_align_nearest_point_cost_checker
   import rnpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [4*CRD_W-1:0]   req_tdata,
   input  wire logic                 req_tlast,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [COST_W-1:0]    rsp_tdata,
   input  wire logic                 rsp_tuser,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CRD_W-1:0]     csr_data,
   output int                        fail_count,
   output int                        pending_costs,
   output int                        cost_items_seen
);

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              no_match;
   } cost_item_type;

   cost_item_type cost_queue[$];

   longint px_mem[MAX_PAIRS_DEF], py_mem[MAX_PAIRS_DEF];
   longint qx_mem[MAX_PAIRS_DEF], qy_mem[MAX_PAIRS_DEF];
   longint acc_x, acc_y;
   int     held;
   longint m00, m01, m10, m11, tr_x, tr_y;
   logic   have_match;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mean_nearest();
      longint n, cx, cy, dx, dy, tx, ty, ex, ey;
      longint unsigned total, best, d2, d;
      n = held;
      cx = floor_div(2 * acc_x + n, 2 * n);
      cy = floor_div(2 * acc_y + n, 2 * n);
      total = 0;
      for (int i = 0; i < held; i++) begin
         dx = px_mem[i] - cx;
         dy = py_mem[i] - cy;
         tx = floor_div(m00 * dx + m01 * dy + 8192, 16384) + tr_x + cx;
         ty = floor_div(m10 * dx + m11 * dy + 8192, 16384) + tr_y + cy;
         best = '1;
         for (int j = 0; j < held; j++) begin
            ex = tx - qx_mem[j];
            ey = ty - qy_mem[j];
            d2 = longint'(ex * ex) + longint'(ey * ey);
            if (j == 0 || d2 < best) best = d2;
         end
         d = int_sqrt(best);
         if (d < DIST_LIMIT) total += d;
      end
      total /= n;
      if (total > 24'hFFFFFF) total = 24'hFFFFFF;
      return total;
   endfunction

   always @(posedge clock) begin
      cost_item_type want;
      if (reset) begin
         acc_x = 0; acc_y = 0; held = 0;
         m00 = 16384; m01 = 0; m10 = 0; m11 = 16384;
         tr_x = 0; tr_y = 0; have_match = 0;
         fail_count <= 0;
         cost_items_seen <= 0;
         cost_queue.delete();
         pending_costs <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROT_00:  m00 = $signed(csr_data[15:0]);
               CSR_ROT_01:  m01 = $signed(csr_data[15:0]);
               CSR_ROT_10:  m10 = $signed(csr_data[15:0]);
               CSR_ROT_11:  m11 = $signed(csr_data[15:0]);
               CSR_SHIFT_X: tr_x = $signed(csr_data);
               CSR_SHIFT_Y: tr_y = $signed(csr_data);
               CSR_MATCH:   have_match = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (held < MAX_PAIRS_DEF) begin
               px_mem[held] = $signed(req_tdata[23:0]);
               py_mem[held] = $signed(req_tdata[47:24]);
               qx_mem[held] = $signed(req_tdata[71:48]);
               qy_mem[held] = $signed(req_tdata[95:72]);
               acc_x = acc_x + px_mem[held];
               acc_y = acc_y + py_mem[held];
               held++;
            end
            if (req_tlast) begin
               if (have_match) want = '{cost: mean_nearest(), no_match: 1'b0};
               else            want = '{cost: '0, no_match: 1'b1};
               cost_queue = {cost_queue, want};
               acc_x = 0; acc_y = 0; held = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            cost_items_seen <= cost_items_seen + 1;
            if (cost_queue.size() == 0) begin
               $display("%0t: unexpected result item cost=%0d no_match=%0b",
                        $time, rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = cost_queue.pop_front();
               if (want.cost !== rsp_tdata || want.no_match !== rsp_tuser) begin
                  $display("%0t: mismatch expected cost=%0d no_match=%0b, got %0d %0b",
                           $time, want.cost, want.no_match, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_costs <= cost_queue.size();
      end
   end

endmodule

// ----- dv/rigid_align_nearest_point_cost_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rigid_align_nearest_point_cost_core_tb
// Drives point-pair sets and register writes into the cost core; a checker
// predicts and compares the results, and this top gives the verdict.
// ----------------------------------------------------------------------------
module rigid_align_nearest_point_cost_core_tb;
   import rnpc_pkg::*;

   logic                 clock, reset;
   logic                 req_tvalid, req_tready, req_tlast;
   logic [4*CRD_W-1:0]   req_tdata;   // prev_x, prev_y, cur_x, cur_y
   logic                 rsp_tvalid, rsp_tready, rsp_tuser;
   logic [COST_W-1:0]    rsp_tdata;   // mean_cost
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CRD_W-1:0]     csr_data;
   int                   fail_count, pending_costs, cost_items_seen;
   int                   idle_cycles, sets_sent, pairs_sent;
   logic                 rsp_stall_on;

   // room for a full 256-pair set plus a long stall on top
   localparam int IDLE_LIMIT = 400000;

   rigid_align_nearest_point_cost_core dut (.*);

   rigid_align_nearest_point_cost_checker chk (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver backpressure, with stall-free stretches
   initial begin
      int g;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (rsp_stall_on) begin
            g = gap_len();
            rsp_tready = 0;
            repeat (g) @(negedge clock);
         end
         rsp_tready = 1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("rigid_align_nearest_point_cost_core test failed");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CRD_W-1:0] val);
      csr_valid = 1; csr_index = idx; csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // wait until all predicted results are back, then let the core settle
   task automatic drain();
      while (pending_costs != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic send_pair(input logic [23:0] px, py, qx, qy, input logic last);
      int g;
      g = gap_len();
      repeat (g) @(negedge clock);
      req_tvalid = 1; req_tdata = {qy, qx, py, px}; req_tlast = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 0;
      pairs_sent++;
      if (last) sets_sent++;
   endtask

   function automatic logic [23:0] rnd_coord(input int mode);
      case (mode)
         0: return 24'($urandom());
         1: return 24'($signed($urandom_range(0, 4000)) - 2000);
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   // one set of n pairs; most current points near the previous ones for deep scans
   task automatic send_set(input int n, input int mode);
      logic [23:0] px, py, qx, qy;
      for (int i = 0; i < n; i++) begin
         px = rnd_coord(mode); py = rnd_coord(mode);
         if ($urandom_range(0, 3) == 0) begin
            qx = rnd_coord(mode); qy = rnd_coord(mode);
         end else begin
            qx = px + 24'($signed($urandom_range(0, 64)) - 32);
            qy = py + 24'($signed($urandom_range(0, 64)) - 32);
         end
         send_pair(px, py, qx, qy, i == n - 1);
      end
   endtask

   task automatic random_regs();
      write_reg(CSR_ROT_00, CRD_W'($urandom()));
      write_reg(CSR_ROT_01, CRD_W'($urandom()));
      write_reg(CSR_ROT_10, CRD_W'($urandom()));
      write_reg(CSR_ROT_11, CRD_W'($urandom()));
      write_reg(CSR_SHIFT_X,
                CRD_W'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 512)));
      write_reg(CSR_SHIFT_Y,
                CRD_W'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 512)));
      write_reg(CSR_MATCH, CRD_W'($urandom_range(0, 9) != 0));
   endtask

   initial begin
      req_tvalid = 0; req_tdata = '0; req_tlast = 0;
      csr_valid = 0; csr_index = CSR_ROT_00; csr_data = '0;
      rsp_stall_on = 1; sets_sent = 0; pairs_sent = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: no match at reset, single pair
      send_pair(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b1);
      drain();
      write_reg(CSR_MATCH, 24'd1);
      // identity, extreme coordinates
      send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b0);
      send_pair(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
      send_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
      send_pair(24'hFFFFFF, 24'h000001, 24'h000100, 24'hFFFF00, 1'b0);
      send_pair(24'h000100, 24'hFFFF00, 24'hFFFFFF, 24'h000001, 1'b1);
      drain();
      // extreme matrix and shifts
      write_reg(CSR_ROT_00, 24'h008000); write_reg(CSR_ROT_01, 24'h007FFF);
      write_reg(CSR_ROT_10, 24'h007FFF); write_reg(CSR_ROT_11, 24'h008000);
      write_reg(CSR_SHIFT_X, 24'h7FFFFF); write_reg(CSR_SHIFT_Y, 24'h800000);
      send_set(3, 2);
      send_set(4, 1);
      drain();
      write_reg(CSR_SHIFT_X, 24'h800000); write_reg(CSR_SHIFT_Y, 24'h7FFFFF);
      send_set(3, 0);
      drain();
      // overflowing set: the last 4 pairs are dropped
      write_reg(CSR_ROT_00, 24'd16384); write_reg(CSR_ROT_01, 24'd0);
      write_reg(CSR_ROT_10, 24'd0); write_reg(CSR_ROT_11, 24'd16384);
      write_reg(CSR_SHIFT_X, 24'd0); write_reg(CSR_SHIFT_Y, 24'd0);
      rsp_stall_on = 0;
      send_set(MAX_PAIRS_DEF + 4, 1);
      drain();
      rsp_stall_on = 1;

      // random sets, mostly small; register settings change between phases
      while (pairs_sent < 750) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            random_regs();
         end
         if ($urandom_range(0, 4) == 0) drain();
         rsp_stall_on = $urandom_range(0, 3) != 0;
         send_set($urandom_range(0, 15) == 0 ? int'($urandom_range(9, 24))
                                             : int'($urandom_range(1, 8)),
                  int'($urandom_range(0, 3)));
      end

      drain();
      repeat (200) @(negedge clock);
      $display("covered %0d pair items in %0d sets, %0d result items checked",
               pairs_sent, sets_sent, cost_items_seen);
      if (fail_count == 0 && pending_costs == 0)
         $display("rigid_align_nearest_point_cost_core test passed");
      else
         $display("rigid_align_nearest_point_cost_core test failed");
      $finish;
   end

endmodule

// ----- rigid_align_nearest_point_cost_core.f -----
rtl/rnpc_pkg.sv
rtl/rnpc_div.sv
rtl/rnpc_sqrt.sv
rtl/rigid_align_nearest_point_cost_core.sv
dv/rigid_align_nearest_point_cost_checker.sv
dv/rigid_align_nearest_point_cost_core_tb.sv
